FILE: design/md5_pkg.sv
// Shared types, constants and round functions for the MD5 digest unit.
`timescale 1ns / 1ps
`default_nettype none

package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [1:0]  LAST_IDX = 2'd3;

  localparam logic [31:0] K_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TAB [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // what happens after the fold of a finished block
  typedef enum logic [1:0] {
    PH_NONE = 2'd0,  // back to taking bytes
    PH_PAD  = 2'd1,  // end of message seen, padding still to write
    PH_LEN  = 2'd2,  // extra block holding only the length follows
    PH_DONE = 2'd3   // digest is ready
  } md5_phase_t;

  typedef struct packed {
    logic       absorb;
    logic       pad;
    logic       lenblk;
    logic       load;
    logic       round;
    logic       fold;
    logic       restart;
    logic [1:0] out_idx;
  } md5_cmd_t;

  typedef struct packed {
    logic block_full;  // next byte completes the block
    logic pad_two;     // padding spills into a second block
    logic round_last;
  } md5_sts_t;

  function automatic logic [31:0] k_const(input logic [5:0] r);
    return K_TAB[r];
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    return ROT_TAB[{r[5:4], r[1:0]}];
  endfunction

  function automatic logic [3:0] msg_idx(input logic [5:0] r);
    logic [3:0] v;
    v = r[3:0];
    unique case (r[5:4])
      2'd0: return v;
      2'd1: return 4'((v << 2) + v + 4'd1);
      2'd2: return 4'((v << 1) + v + 4'd5);
      default: return 4'((v << 3) - v);
    endcase
  endfunction

  function automatic logic [31:0] round_f(input logic [5:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    unique case (r[5:4])
      2'd0: return (b & c) | (~b & d);
      2'd1: return (b & d) | (c & ~d);
      2'd2: return b ^ c ^ d;
      default: return c ^ (b | ~d);
    endcase
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

endpackage

`default_nettype wire

FILE: design/md5_dp.sv
// MD5 datapath: block buffer, byte count, round registers and chaining words.
`timescale 1ns / 1ps
`default_nettype none

module md5_dp import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  md5_cmd_t    cmd,
  input  logic [7:0]  msg_byte,
  output md5_sts_t    sts,
  output logic [31:0] digest_word
);

  logic [31:0] blk [16];
  logic [31:0] blk_next [16];
  logic [31:0] chain [4];
  logic [31:0] wa, wb, wc, wd;
  logic [31:0] pre;
  logic [5:0]  rnd;
  logic [60:0] byte_cnt;

  logic [5:0]  pos;
  logic [3:0]  wsel;
  logic [1:0]  lsel;
  logic [7:0]  ins;
  logic        pad_two;
  logic [31:0] len_lo, len_hi;
  logic [5:0]  rnd_n;
  logic [31:0] f_val, new_b, pre_next;

  assign pos     = byte_cnt[5:0];
  assign wsel    = pos[5:2];
  assign lsel    = pos[1:0];
  assign pad_two = (pos[5:3] == 3'b111);
  assign ins     = cmd.pad ? PAD_BYTE : msg_byte;
  assign len_lo  = {byte_cnt[28:0], 3'b000};
  assign len_hi  = byte_cnt[60:29];

  assign sts.block_full = (pos == 6'd63);
  assign sts.pad_two    = pad_two;
  assign sts.round_last = (rnd == 6'd63);

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      blk_next[i] = blk[i];
      if (cmd.absorb || cmd.pad) begin
        if (4'(i) == wsel) begin
          for (int j = 0; j < 4; j++) begin
            if (2'(j) == lsel) begin
              blk_next[i][8*j +: 8] = ins;
            end else if (2'(j) > lsel) begin
              blk_next[i][8*j +: 8] = 8'd0;
            end
          end
        end else if (cmd.pad && (4'(i) > wsel)) begin
          blk_next[i] = 32'd0;
        end
      end
      if (cmd.lenblk) begin
        blk_next[i] = 32'd0;
      end
      // bit length goes in the top two words of the final block
      if (cmd.lenblk || (cmd.pad && !pad_two)) begin
        if (i == 14) begin
          blk_next[i] = len_lo;
        end else if (i == 15) begin
          blk_next[i] = len_hi;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    blk <= blk_next;
  end

  // pre holds a + K + M of the coming round, so a round is one add, rotate, add
  assign rnd_n    = rnd + 6'd1;
  assign f_val    = round_f(rnd, wb, wc, wd);
  assign new_b    = wb + rotl(pre + f_val, rot_amt(rnd));
  assign pre_next = wd + k_const(rnd_n) + blk[msg_idx(rnd_n)];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wa  <= chain[0];
      wb  <= chain[1];
      wc  <= chain[2];
      wd  <= chain[3];
      pre <= chain[0] + k_const(6'd0) + blk[0];
    end else if (cmd.round) begin
      wa  <= wd;
      wd  <= wc;
      wc  <= wb;
      wb  <= new_b;
      pre <= pre_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0] <= IV_A;
      chain[1] <= IV_B;
      chain[2] <= IV_C;
      chain[3] <= IV_D;
      byte_cnt <= '0;
      rnd      <= '0;
    end else begin
      if (cmd.load) begin
        rnd <= '0;
      end else if (cmd.round) begin
        rnd <= rnd_n;
      end
      if (cmd.absorb) begin
        byte_cnt <= byte_cnt + 61'd1;
      end
      if (cmd.restart) begin
        chain[0] <= IV_A;
        chain[1] <= IV_B;
        chain[2] <= IV_C;
        chain[3] <= IV_D;
        byte_cnt <= '0;
      end else if (cmd.fold) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
      end
    end
  end

  assign digest_word = chain[cmd.out_idx];

endmodule

`default_nettype wire

FILE: design/md5_ctrl.sv
// MD5 controller: sequences byte intake, padding, block rounds and digest output.
`timescale 1ns / 1ps
`default_nettype none

module md5_ctrl import md5_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_has_byte,
  input  logic     in_last,
  input  logic     out_ready,
  input  md5_sts_t sts,
  output logic     in_ready,
  output logic     out_valid,
  output md5_cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PAD    = 7'b0000010,
    ST_LOAD   = 7'b0000100,
    ST_ROUND  = 7'b0001000,
    ST_FOLD   = 7'b0010000,
    ST_LENBLK = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  state_t     state, state_next;
  md5_phase_t phase, phase_next;
  logic [1:0] out_idx, out_idx_next;
  logic       take;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign take      = in_valid && in_ready;

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    out_idx_next = out_idx;
    cmd          = '0;
    cmd.out_idx  = out_idx;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          cmd.absorb = in_has_byte;
          if (in_has_byte && sts.block_full) begin
            phase_next = in_last ? PH_PAD : PH_NONE;
            state_next = ST_LOAD;
          end else if (in_last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.pad    = 1'b1;
        phase_next = sts.pad_two ? PH_LEN : PH_DONE;
        state_next = ST_LOAD;
      end
      ST_LENBLK: begin
        cmd.lenblk = 1'b1;
        phase_next = PH_DONE;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (sts.round_last) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        unique case (phase)
          PH_NONE: state_next = ST_IDLE;
          PH_PAD:  state_next = ST_PAD;
          PH_LEN:  state_next = ST_LENBLK;
          PH_DONE: state_next = ST_OUT;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        if (out_ready) begin
          out_idx_next = out_idx + 2'd1;
          if (out_idx == LAST_IDX) begin
            cmd.restart = 1'b1;
            phase_next  = PH_NONE;
            state_next  = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      phase   <= PH_NONE;
      out_idx <= '0;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      out_idx <= out_idx_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/md5_message_digest_unit.sv
// Top level of the MD5 digest unit: stream ports, controller and datapath.
// A byte item is taken while the unit is idle; the item that fills a 64-byte block then runs
// one load, 64 rounds of the single round unit and one fold before the next item is taken.
// An item marked last adds a padding step and then one or two blocks, the second built in a
// length-block step, then the four digest words leave one per cycle while m_tready is high.
// One item is in work at a time. Synchronous reset loads the MD5 initial chaining words,
// zeroes the length and returns the controller to idle; the block buffer is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module md5_message_digest_unit import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] msg_byte
  input  logic        s_tuser,   // [0] has_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [1:0]  m_tuser,   // [1:0] word_index
  output logic        m_tlast    // last_word
);

  md5_cmd_t cmd;
  md5_sts_t sts;

  md5_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_has_byte (s_tuser),
    .in_last     (s_tlast),
    .out_ready   (m_tready),
    .sts         (sts),
    .in_ready    (s_tready),
    .out_valid   (m_tvalid),
    .cmd         (cmd)
  );

  md5_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .msg_byte    (s_tdata),
    .sts         (sts),
    .digest_word (m_tdata)
  );

  assign m_tuser = cmd.out_idx;
  assign m_tlast = (cmd.out_idx == LAST_IDX);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while digest is being sent");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("unit not idle after final digest word");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> (!s_tready && !m_tvalid))
    else $error("end of message did not start padding");

  a_word_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser == $past(m_tuser) + 2'd1))
    else $error("digest words out of order");

endmodule

`default_nettype wire
